>>> sv/dmsr_pkg.sv
// ----------------------------------------------------------------------------
// dmsr_pkg
// Shared widths, codes, register indexes and word layouts for the dual motor
// speed regulator.
// ----------------------------------------------------------------------------
package dmsr_pkg;

    localparam int MOTOR_COUNT_DEF = 2;

    localparam int CMD_W     = 1;
    localparam int MOTOR_W   = 2;
    localparam int SPEED_W   = 16;
    localparam int MAXSPD_W  = 15;
    localparam int FREQ_W    = 16;
    localparam int GAIN_W    = 32;
    localparam int DUTY_W    = 17;
    localparam int ERR_W     = 18;
    localparam int CHG_W     = 19;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET_SPEED = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK      = 1'b1;

    // status codes
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_MOTOR = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FREQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MID_FREQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FREQ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd7;

    // reset values
    localparam logic [MAXSPD_W-1:0]       RST_MAX_SPEED  = 15'd300;
    localparam logic signed [SPEED_W-1:0] RST_LOW_LIMIT  = 16'sd100;
    localparam logic signed [SPEED_W-1:0] RST_MID_LIMIT  = 16'sd200;
    localparam logic [FREQ_W-1:0]         RST_LOW_FREQ   = 16'd100;
    localparam logic [FREQ_W-1:0]         RST_MID_FREQ   = 16'd200;
    localparam logic [FREQ_W-1:0]         RST_HIGH_FREQ  = 16'd400;
    localparam logic [GAIN_W-1:0]         RST_PROP_GAIN  = 32'd8589935;
    localparam logic [GAIN_W-1:0]         RST_DERIV_GAIN = 32'd17179869;
    localparam logic [FREQ_W-1:0]         RST_GEAR_FREQ  = 16'd100;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 17'h10000;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [MOTOR_W-1:0]        motor;
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] rpm_one;
        logic signed [SPEED_W-1:0] rpm_two;
    } t_in_word;

    typedef struct packed {
        logic               status;
        logic               duty_valid;
        logic [DUTY_W-1:0]  duty_one;
        logic [DUTY_W-1:0]  duty_two;
        logic               freq_change;
        logic [MOTOR_W-1:0] freq_motor;
        logic [FREQ_W-1:0]  freq_value;
    } t_out_word;

endpackage

>>> sv/dual_motor_speed_regulator.sv
// ----------------------------------------------------------------------------
// dual_motor_speed_regulator
// Two-motor incremental PD speed regulator with setpoint clamping and PWM gear
// frequency selection.
//
//   channel   dir  handshake       tdata (low bit up)                 tuser
//   s_axis    in   tvalid/tready   motor, speed, rpm_one, rpm_two     cmd
//   m_axis    out  tvalid/tready   duty_one, duty_two, freq_motor,    status,
//                                  freq_value                         duty_valid,
//                                                                     freq_change
//   cfg       in   i_cfg_wr_en     index, data                        -
//
// One word per cycle sustained; a taken word passes the input register, then
// the result register, before its result leaves. Both motors' PD multiply-adds
// sit in the one stage between the registers, so back-to-back ticks chain.
// Synchronous active-low reset restores register defaults and per-motor state.
// s_axis_tready drops only while the input register is full and the result
// register waits on m_axis_tready.
// ----------------------------------------------------------------------------
module dual_motor_speed_regulator #(
    parameter int MOTOR_COUNT = dmsr_pkg::MOTOR_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [dmsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dmsr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // motor[1:0], speed[17:2], rpm_one[33:18], rpm_two[49:34], zero[55:50]
    input  logic [dmsr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  logic [dmsr_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // duty_one[16:0], duty_two[33:17], freq_motor[35:34], freq_value[51:36], zero[55:52]
    output logic [dmsr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // status[0], duty_valid[1], freq_change[2]
    output logic [dmsr_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import dmsr_pkg::*;

    localparam int REG_N = (MOTOR_COUNT > 2) ? 2 : MOTOR_COUNT;
    localparam int SEL_W = $clog2(MOTOR_COUNT + 1) + 1;

    // configuration
    logic [MAXSPD_W-1:0]       r_max_speed;
    logic signed [SPEED_W-1:0] r_low_limit;
    logic signed [SPEED_W-1:0] r_mid_limit;
    logic [FREQ_W-1:0]         r_low_freq;
    logic [FREQ_W-1:0]         r_mid_freq;
    logic [FREQ_W-1:0]         r_high_freq;
    logic [GAIN_W-1:0]         r_kp;
    logic [GAIN_W-1:0]         r_kd;

    // per-motor state
    logic signed [SPEED_W-1:0] r_setpoint [MOTOR_COUNT];
    logic [FREQ_W-1:0]         r_gear     [MOTOR_COUNT];
    logic [DUTY_W-1:0]         r_duty     [REG_N];
    logic signed [ERR_W-1:0]   r_err      [REG_N];

    // pipeline
    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;

    logic      w_move;
    t_out_word n_out;

    // set-speed path
    logic [MOTOR_COUNT-1:0]      w_hit;
    logic [MOTOR_COUNT-1:0]      w_chg;
    logic                        w_motor_ok;
    logic signed [SPEED_W:0]     w_lim;
    logic signed [SPEED_W:0]     w_spd;
    logic signed [SPEED_W:0]     w_clamp17;
    logic signed [SPEED_W-1:0]   w_clamp;
    logic [FREQ_W-1:0]           w_freq;

    // tick path
    logic signed [SPEED_W-1:0]       w_rpm   [REG_N];
    logic signed [ERR_W-1:0]         w_err   [REG_N];
    logic signed [CHG_W-1:0]         w_dchg  [REG_N];
    logic signed [GAIN_W+ERR_W:0]    w_pterm [REG_N];
    logic signed [GAIN_W+CHG_W:0]    w_dterm [REG_N];
    logic signed [GAIN_W+CHG_W+2:0]  w_acc   [REG_N];
    logic [GAIN_W:0]                 w_rnd   [REG_N];
    logic [DUTY_W-1:0]               n_duty  [REG_N];

    assign w_move        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_move;

    // set speed: clamp, gear select, change detect
    always_comb begin
        w_lim = $signed({2'b00, r_max_speed});
        w_spd = (SPEED_W + 1)'(r_in.speed);
        if (w_spd > w_lim) begin
            w_clamp17 = w_lim;
        end else if (w_spd < -w_lim) begin
            w_clamp17 = -w_lim;
        end else begin
            w_clamp17 = w_spd;
        end
        w_clamp = w_clamp17[SPEED_W-1:0];

        if (w_clamp > r_mid_limit) begin
            w_freq = r_high_freq;
        end else if (w_clamp > r_low_limit) begin
            w_freq = r_mid_freq;
        end else begin
            w_freq = r_low_freq;
        end

        for (int k = 0; k < MOTOR_COUNT; k++) begin
            w_hit[k] = ({{(SEL_W-MOTOR_W){1'b0}}, r_in.motor} == SEL_W'(k + 1));
            w_chg[k] = w_hit[k] && (r_gear[k] != w_freq);
        end
        w_motor_ok = |w_hit;
    end

    // tick: incremental PD per regulated motor
    always_comb begin
        for (int k = 0; k < REG_N; k++) begin
            w_rpm[k]   = (k == 0) ? r_in.rpm_one : r_in.rpm_two;
            w_err[k]   = ERR_W'(r_setpoint[k]) - ERR_W'(w_rpm[k]);
            w_dchg[k]  = CHG_W'(w_err[k]) - CHG_W'(r_err[k]);
            w_pterm[k] = (GAIN_W + ERR_W + 1)'($signed({1'b0, r_kp}))
                       * (GAIN_W + ERR_W + 1)'(w_err[k]);
            w_dterm[k] = (GAIN_W + CHG_W + 1)'($signed({1'b0, r_kd}))
                       * (GAIN_W + CHG_W + 1)'(w_dchg[k]);
            w_acc[k]   = (GAIN_W + CHG_W + 3)'($signed({1'b0, r_duty[k], 16'h0000}))
                       + (GAIN_W + CHG_W + 3)'(w_pterm[k])
                       + (GAIN_W + CHG_W + 3)'(w_dterm[k]);
            w_rnd[k]   = {1'b0, w_acc[k][GAIN_W-1:0]} + (GAIN_W + 1)'(32'h8000);
            if (w_acc[k] <= 0) begin
                n_duty[k] = '0;
            end else if (w_acc[k] >= (GAIN_W + CHG_W + 3)'(64'sh1_0000_0000)) begin
                n_duty[k] = DUTY_FULL;
            end else begin
                n_duty[k] = w_rnd[k][GAIN_W:GAIN_W-DUTY_W+1];
            end
        end
    end

    // result word
    always_comb begin
        n_out = '0;
        if (r_in.cmd == CMD_TICK) begin
            n_out.status     = ST_OK;
            n_out.duty_valid = 1'b1;
            for (int k = 0; k < REG_N; k++) begin
                if (k == 0) begin
                    n_out.duty_one = n_duty[k];
                end else begin
                    n_out.duty_two = n_duty[k];
                end
            end
        end else if (!w_motor_ok) begin
            n_out.status = ST_BAD_MOTOR;
        end else begin
            n_out.status = ST_OK;
            if (|w_chg) begin
                n_out.freq_change = 1'b1;
                n_out.freq_motor  = r_in.motor;
                n_out.freq_value  = w_freq;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= RST_MAX_SPEED;
            r_low_limit <= RST_LOW_LIMIT;
            r_mid_limit <= RST_MID_LIMIT;
            r_low_freq  <= RST_LOW_FREQ;
            r_mid_freq  <= RST_MID_FREQ;
            r_high_freq <= RST_HIGH_FREQ;
            r_kp        <= RST_PROP_GAIN;
            r_kd        <= RST_DERIV_GAIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MAX_SPEED:  r_max_speed <= i_cfg_wdata[MAXSPD_W-1:0];
                REG_LOW_LIMIT:  r_low_limit <= $signed(i_cfg_wdata[SPEED_W-1:0]);
                REG_MID_LIMIT:  r_mid_limit <= $signed(i_cfg_wdata[SPEED_W-1:0]);
                REG_LOW_FREQ:   r_low_freq  <= i_cfg_wdata[FREQ_W-1:0];
                REG_MID_FREQ:   r_mid_freq  <= i_cfg_wdata[FREQ_W-1:0];
                REG_HIGH_FREQ:  r_high_freq <= i_cfg_wdata[FREQ_W-1:0];
                REG_PROP_GAIN:  r_kp        <= i_cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN: r_kd        <= i_cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per-motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_setpoint[k] <= '0;
                r_gear[k]     <= RST_GEAR_FREQ;
            end
            for (int k = 0; k < REG_N; k++) begin
                r_duty[k] <= '0;
                r_err[k]  <= '0;
            end
        end else if (w_move) begin
            if (r_in.cmd == CMD_TICK) begin
                for (int k = 0; k < REG_N; k++) begin
                    r_duty[k] <= n_duty[k];
                    r_err[k]  <= w_err[k];
                end
            end else begin
                for (int k = 0; k < MOTOR_COUNT; k++) begin
                    if (w_hit[k]) begin
                        r_setpoint[k] <= w_clamp;
                    end
                    if (w_chg[k]) begin
                        r_gear[k] <= w_freq;
                    end
                end
            end
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.cmd     <= s_axis_tuser[0];
            r_in.motor   <= s_axis_tdata[1:0];
            r_in.speed   <= $signed(s_axis_tdata[17:2]);
            r_in.rpm_one <= $signed(s_axis_tdata[33:18]);
            r_in.rpm_two <= $signed(s_axis_tdata[49:34]);
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'h0, r_out.freq_value, r_out.freq_motor,
                            r_out.duty_two, r_out.duty_one};
    assign m_axis_tuser  = {r_out.freq_change, r_out.duty_valid, r_out.status};

endmodule

>>> tb/sv/dual_motor_speed_regulator_tb.sv
// ----------------------------------------------------------------------------
// dual_motor_speed_regulator_tb
// Self-checking bench for the two-motor PD speed regulator. A directed table
// covers reset behavior, field extremes, bad motor numbers and the gear
// thresholds, then phases of random set-speed and tick words run under
// different register settings. Every result word is compared field by field
// with its table entry or an in-bench model of the setpoint, gear and duty
// arithmetic, while both stream sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module dual_motor_speed_regulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmsr_pkg::*;

    localparam int CYCLE_LIMIT    = 400_000;
    localparam int PHASES         = 8;
    localparam int WORDS_PER_PHASE = 235;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word r;
    } t_dir_row;

    localparam t_out_word OUT_QUIET = '0;
    localparam t_out_word OUT_BAD   = '{ST_BAD_MOTOR, 1'b0, 17'd0, 17'd0, 1'b0, 2'd0, 16'd0};

    localparam t_dir_row DIRECTED [22] = '{
        '{'{CMD_TICK, 2'd3, 16'shFFFF, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 1'b1, 17'd0, 17'd0, 1'b0, 2'd0, 16'd0}},
        '{'{CMD_TICK, 2'd0, 16'sh7FFF, 16'sh8000, 16'sh8000}, 1'b1,
          '{ST_OK, 1'b1, DUTY_FULL, DUTY_FULL, 1'b0, 2'd0, 16'd0}},
        '{'{CMD_TICK, 2'd1, 16'sh8000, 16'sh7FFF, 16'sh7FFF}, 1'b1,
          '{ST_OK, 1'b1, 17'd0, 17'd0, 1'b0, 2'd0, 16'd0}},
        '{'{CMD_SET_SPEED, 2'd0, 16'sd500, 16'sh5555, 16'shAAAA}, 1'b1, OUT_BAD},
        '{'{CMD_SET_SPEED, 2'd3, -16'sd500, 16'shAAAA, 16'sh5555}, 1'b1, OUT_BAD},
        '{'{CMD_SET_SPEED, 2'd1, 16'sh7FFF, 16'shFFFF, 16'sh0000}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd1, 16'd400}},
        '{'{CMD_SET_SPEED, 2'd2, 16'sh8000, 16'sh0000, 16'shFFFF}, 1'b1, OUT_QUIET},
        '{'{CMD_TICK, 2'd2, 16'sh1234, 16'sd300, -16'sd300}, 1'b0, OUT_QUIET},
        '{'{CMD_TICK, 2'd0, 16'sh4321, 16'sd290, -16'sd310}, 1'b0, OUT_QUIET},
        '{'{CMD_TICK, 2'd3, 16'sh0F0F, 16'sd295, -16'sd295}, 1'b0, OUT_QUIET},
        '{'{CMD_SET_SPEED, 2'd1, 16'sd150, 16'sd1, 16'sd2}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd1, 16'd200}},
        '{'{CMD_SET_SPEED, 2'd1, 16'sd150, 16'sd3, 16'sd4}, 1'b1, OUT_QUIET},
        '{'{CMD_SET_SPEED, 2'd2, 16'sd101, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd2, 16'd200}},
        '{'{CMD_SET_SPEED, 2'd2, 16'sd100, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd2, 16'd100}},
        '{'{CMD_SET_SPEED, 2'd2, 16'sd200, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd2, 16'd200}},
        '{'{CMD_SET_SPEED, 2'd2, 16'sd201, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd2, 16'd400}},
        '{'{CMD_SET_SPEED, 2'd1, -16'sd1, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd1, 16'd100}},
        '{'{CMD_TICK, 2'd1, 16'sd0, 16'sd140, 16'sd190}, 1'b0, OUT_QUIET},
        '{'{CMD_TICK, 2'd2, 16'sd0, 16'sd160, 16'sd210}, 1'b0, OUT_QUIET},
        '{'{CMD_TICK, 2'd0, 16'sd0, -16'sd1, 16'sd201}, 1'b0, OUT_QUIET},
        '{'{CMD_SET_SPEED, 2'd2, 16'sh8000, 16'sd0, 16'sd0}, 1'b1,
          '{ST_OK, 1'b0, 17'd0, 17'd0, 1'b1, 2'd2, 16'd100}},
        '{'{CMD_TICK, 2'd3, 16'shFFFF, 16'sh8000, 16'sh7FFF}, 1'b0, OUT_QUIET}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [S_TUSER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    // regulator copy: configuration
    int     max_spd, low_lim, mid_lim, freq_lo, freq_mid, freq_hi;
    longint kp, kd;
    // regulator copy: per-motor state
    int     setpt [2];
    longint duty_st [2];
    int     err_st [2];
    int     gear_st [2];

    t_out_word regulator_out_q [$];
    int        mismatches;
    int        words_seen;
    int        cycle_cnt;
    int        idle_pct;
    int        stall_pct;

    dual_motor_speed_regulator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_regulator();
        max_spd  = RST_MAX_SPEED;
        low_lim  = RST_LOW_LIMIT;
        mid_lim  = RST_MID_LIMIT;
        freq_lo  = RST_LOW_FREQ;
        freq_mid = RST_MID_FREQ;
        freq_hi  = RST_HIGH_FREQ;
        kp       = longint'(RST_PROP_GAIN);
        kd       = longint'(RST_DERIV_GAIN);
        for (int m = 0; m < 2; m++) begin
            setpt[m]   = 0;
            duty_st[m] = 0;
            err_st[m]  = 0;
            gear_st[m] = RST_GEAR_FREQ;
        end
    endfunction

    function automatic logic [DUTY_W-1:0] pd_duty(input int m, input int rpm);
        int     err;
        longint chg;
        longint acc;
        longint d;
        err = setpt[m] - rpm;
        chg = longint'(err) - longint'(err_st[m]);
        acc = (duty_st[m] <<< 16) + kp * longint'(err) + kd * chg;
        if (acc <= 0)
            d = 0;
        else if (acc >= (64'sd1 <<< 32))
            d = 65536;
        else
            d = (acc + 32768) >>> 16;
        duty_st[m] = d;
        err_st[m]  = err;
        return d[DUTY_W-1:0];
    endfunction

    function automatic t_out_word regulate_word(input t_in_word w);
        t_out_word r;
        int        m;
        int        spd;
        int        f;
        r = '0;
        if (w.cmd == CMD_TICK) begin
            r.duty_valid = 1'b1;
            r.duty_one   = pd_duty(0, w.rpm_one);
            r.duty_two   = pd_duty(1, w.rpm_two);
            return r;
        end
        if (w.motor < 1 || w.motor > MOTOR_COUNT_DEF) begin
            r.status = ST_BAD_MOTOR;
            return r;
        end
        m   = w.motor - 1;
        spd = w.speed;
        if (spd > max_spd) spd = max_spd;
        if (spd < -max_spd) spd = -max_spd;
        setpt[m] = spd;
        if (spd > mid_lim)
            f = freq_hi;
        else if (spd > low_lim)
            f = freq_mid;
        else
            f = freq_lo;
        if (gear_st[m] != f) begin
            gear_st[m]    = f;
            r.freq_change = 1'b1;
            r.freq_motor  = w.motor;
            r.freq_value  = f[FREQ_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] clip16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic int near_delta();
        int mag;
        mag = int'($urandom_range(0, 1 << $urandom_range(0, 12)));
        return ($urandom_range(0, 1) != 0) ? mag : -mag;
    endfunction

    function automatic t_in_word pick_word();
        t_in_word w;
        int       r;
        int       base;
        w.cmd     = CMD_TICK;
        w.motor   = 2'($urandom);
        w.speed   = 16'($urandom);
        w.rpm_one = 16'($urandom);
        w.rpm_two = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) begin
            w.cmd   = CMD_SET_SPEED;
            w.motor = ($urandom_range(0, 1) != 0) ? 2'd0 : 2'd3;
        end else if (r < 35) begin
            w.cmd   = CMD_SET_SPEED;
            w.motor = 2'($urandom_range(1, 2));
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0: base = low_lim;
                    1: base = mid_lim;
                    2: base = max_spd;
                    default: base = -max_spd;
                endcase
                w.speed = clip16(base + int'($urandom_range(0, 6)) - 3);
            end
        end else if ($urandom_range(0, 4) != 0) begin
            w.rpm_one = clip16(setpt[0] + near_delta());
            w.rpm_two = clip16(setpt[1] + near_delta());
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH word %0d: %s", $time, words_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        case (idx)
            REG_MAX_SPEED:  max_spd  = data[MAXSPD_W-1:0];
            REG_LOW_LIMIT:  low_lim  = $signed(data[SPEED_W-1:0]);
            REG_MID_LIMIT:  mid_lim  = $signed(data[SPEED_W-1:0]);
            REG_LOW_FREQ:   freq_lo  = data[FREQ_W-1:0];
            REG_MID_FREQ:   freq_mid = data[FREQ_W-1:0];
            REG_HIGH_FREQ:  freq_hi  = data[FREQ_W-1:0];
            REG_PROP_GAIN:  kp       = longint'(data);
            REG_DERIV_GAIN: kd       = longint'(data);
            default: ;
        endcase
    endtask

    task automatic configure_phase(input int ph);
        logic [31:0] v_max, v_low, v_mid, v_flo, v_fmid, v_fhi, v_kp, v_kd;
        int          mx, lo_i, mid_i;
        v_max = $urandom;
        mx    = v_max[MAXSPD_W-1:0];
        lo_i  = int'($urandom_range(0, 2 * mx)) - mx;
        mid_i = lo_i + int'($urandom_range(0, mx));
        v_low  = {16'($urandom), clip16(lo_i)};
        v_mid  = {16'($urandom), clip16(mid_i)};
        v_flo  = $urandom;
        v_fmid = $urandom;
        v_fhi  = $urandom;
        v_kp   = $urandom >> $urandom_range(0, 24);
        v_kd   = $urandom >> $urandom_range(0, 24);
        case (ph)
            0: begin
                // reset values, junk above the register widths
                v_max  = 32'hFFFF_812C;
                v_low  = 32'hABCD_0064;
                v_mid  = 32'h1234_00C8;
                v_flo  = 32'hFFFF_0064;
                v_fmid = 32'h0001_00C8;
                v_fhi  = 32'h8000_0190;
                v_kp   = RST_PROP_GAIN;
                v_kd   = RST_DERIV_GAIN;
            end
            1: begin
                v_max  = 32'h0000_7FFF;
                v_low  = 32'h0000_8000;
                v_mid  = 32'h0000_7FFF;
                v_flo  = 32'h0000_0001;
                v_fmid = 32'h0000_FFFF;
                v_fhi  = 32'h0000_8000;
                v_kp   = 32'hFFFF_FFFF;
                v_kd   = 32'hFFFF_FFFF;
            end
            2: begin
                // zero speed limit: every setpoint clamps to zero
                v_max = 32'hFFFF_8000;
                v_kp  = 32'h0;
                v_kd  = 32'h0;
            end
            3: begin
                v_max = 32'h0000_0001;
                v_low = 32'h0000_7FFF;
                v_mid = 32'h0000_8000;
                v_kd  = 32'h0;
            end
            default: ;
        endcase
        write_reg(REG_MAX_SPEED, v_max);
        write_reg(REG_LOW_LIMIT, v_low);
        write_reg(REG_MID_LIMIT, v_mid);
        write_reg(REG_LOW_FREQ, v_flo);
        write_reg(REG_MID_FREQ, v_fmid);
        write_reg(REG_HIGH_FREQ, v_fhi);
        write_reg(REG_PROP_GAIN, v_kp);
        write_reg(REG_DERIV_GAIN, v_kd);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word typed_r);
        int        gap;
        t_out_word want;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'b0, w.rpm_two, w.rpm_one, w.speed, w.motor};
        s_axis_tuser  = w.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        want = regulate_word(w);
        regulator_out_q.push_back(typed ? typed_r : want);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (regulator_out_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stall bursts
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 14);
                m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.duty_one    = m_axis_tdata[16:0];
            got.duty_two    = m_axis_tdata[33:17];
            got.freq_motor  = m_axis_tdata[35:34];
            got.freq_value  = m_axis_tdata[51:36];
            got.status      = m_axis_tuser[0];
            got.duty_valid  = m_axis_tuser[1];
            got.freq_change = m_axis_tuser[2];
            if (regulator_out_q.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = regulator_out_q.pop_front();
                check_field("status", got.status, want.status);
                check_field("duty_valid", got.duty_valid, want.duty_valid);
                check_field("duty_one", got.duty_one, want.duty_one);
                check_field("duty_two", got.duty_two, want.duty_two);
                check_field("freq_change", got.freq_change, want.freq_change);
                check_field("freq_motor", got.freq_motor, want.freq_motor);
                check_field("freq_value", got.freq_value, want.freq_value);
            end
            words_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        words_seen    = 0;
        cycle_cnt     = 0;
        idle_pct      = 20;
        stall_pct     = 20;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        reset_regulator();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].r);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 3)
                0: begin idle_pct = 0;  stall_pct = 35; end
                1: begin idle_pct = 10; stall_pct = 0;  end
                default: begin idle_pct = 35; stall_pct = 10; end
            endcase
            // closing stretch runs at full rate
            if (ph == PHASES - 1) begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            configure_phase(ph);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(pick_word(), 1'b0, OUT_QUIET);
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> dual_motor_speed_regulator.f
sv/dmsr_pkg.sv
sv/dual_motor_speed_regulator.sv
tb/sv/dual_motor_speed_regulator_tb.sv
